// File: rtl/imefr_pkg.sv
// ----------------------------------------------------------------------------
// imefr_pkg
// Shared types and constants for the interrupt enable and flag register block.
// ----------------------------------------------------------------------------
package imefr_pkg;

    // Item kinds carried on the input tuser field.
    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_REQUEST = 2'd2
    } op_t;

    // Register byte offsets (low 12 bits of the I/O address).
    localparam logic [11:0] OFS_MASTER  = 12'h208;
    localparam logic [11:0] OFS_ENABLE  = 12'h210;
    localparam logic [11:0] OFS_PENDING = 12'h214;
    localparam logic [11:0] OFS_POST    = 12'h300;

    // Bits of the enable mask that can ever be set.
    localparam logic [31:0] ENABLE_IMPL = 32'h003F_3F7F;

    // Packed field widths of the item channels.
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 16;

    // Writable bits of each enable mask byte.
    function automatic logic [7:0] enable_keep(input logic [1:0] idx);
        logic [7:0] keep;
        case (idx)
            2'd0:    keep = 8'h7F;
            2'd1:    keep = 8'h3F;
            2'd2:    keep = 8'h3F;
            default: keep = 8'h00;
        endcase
        return keep;
    endfunction

endpackage

// File: rtl/interrupt_master_enable_flag_regs.sv
// ----------------------------------------------------------------------------
// interrupt_master_enable_flag_regs
// Byte-wide register block holding the interrupt master enable, enable mask,
// pending flags and power-on flag, with a level interrupt output per item.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_*) carries one bus access or source request per item:
// s_tuser holds the kind (read, write, request), s_tdata holds the offset,
// the write byte and the request bits. The output channel (m_*) returns one
// item for every input item: the read byte, the interrupt level after the
// item has taken effect, and a miss flag for undecoded offsets.
// Each item is decoded and applied to the registers in the cycle it is
// accepted; its result appears in the output register on the next cycle,
// and one item is taken every cycle while the receiver keeps m_tready high.
// The single output register sets that rate.
// When the receiver stalls, the result holds in the output register and the
// input side stops accepting until it is taken, so the registers see no
// further update meanwhile.
// Reset clears the state registers and leaves the output channel empty.
// ----------------------------------------------------------------------------
module interrupt_master_enable_flag_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [11:0] io_offset, [19:12] write_data, [51:20] request_bits, rest zero
    input  logic [imefr_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] operation
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] read_data, [8] irq_line, [9] miss, rest zero
    output logic [imefr_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import imefr_pkg::*;

    // Unpacked input fields.
    op_t         op;
    logic [11:0] ofs;
    logic [7:0]  wdata;
    logic [31:0] req_bits;

    // Architectural state.
    logic        master_reg, master_next;
    logic [31:0] enable_reg, enable_next;
    logic [31:0] pending_reg, pending_next;
    logic [1:0]  post_reg, post_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  rdata_reg, rdata_next;
    logic        irq_reg, irq_next;
    logic        miss_reg, miss_next;

    // Decode helpers.
    logic        accept;
    logic        hit_master, hit_reserved, hit_enable, hit_pending, hit_post, hit_any;
    logic [4:0]  byte_sh;
    logic [7:0]  rd_byte;
    logic [31:0] byte_field;

    assign op       = op_t'(s_tuser);
    assign ofs      = s_tdata[11:0];
    assign wdata    = s_tdata[19:12];
    assign req_bits = s_tdata[51:20];

    // Accept while the output register is empty or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Offset decode: the four-byte groups match on the upper ten bits.
    assign hit_master   = (ofs == OFS_MASTER);
    assign hit_reserved = (ofs[11:2] == OFS_MASTER[11:2]) && (ofs[1:0] != 2'd0);
    assign hit_enable   = (ofs[11:2] == OFS_ENABLE[11:2]);
    assign hit_pending  = (ofs[11:2] == OFS_PENDING[11:2]);
    assign hit_post     = (ofs == OFS_POST);
    assign hit_any      = hit_master || hit_reserved || hit_enable
                          || hit_pending || hit_post;
    assign byte_sh      = {ofs[1:0], 3'b000};
    assign byte_field   = {24'd0, wdata} << byte_sh;

    // Read byte mux.
    always_comb
    begin
        rd_byte = 8'd0;
        if (hit_master)
        begin
            rd_byte = {7'd0, master_reg};
        end
        else if (hit_enable)
        begin
            rd_byte = 8'(enable_reg >> byte_sh);
        end
        else if (hit_pending)
        begin
            rd_byte = 8'(pending_reg >> byte_sh);
        end
        else if (hit_post)
        begin
            rd_byte = {6'd0, post_reg};
        end
    end

    // Register updates and result for the accepted item.
    always_comb
    begin
        master_next    = master_reg;
        enable_next    = enable_reg;
        pending_next   = pending_reg;
        post_next      = post_reg;
        out_valid_next = out_valid_reg && !m_tready;
        rdata_next     = rdata_reg;
        irq_next       = irq_reg;
        miss_next      = miss_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            rdata_next     = 8'd0;
            miss_next      = 1'b0;
            case (op)
                OP_READ:
                begin
                    rdata_next = rd_byte;
                    miss_next  = !hit_any;
                end
                OP_WRITE:
                begin
                    miss_next = !hit_any;
                    if (hit_master)
                    begin
                        master_next = wdata[0];
                    end
                    if (hit_enable)
                    begin
                        enable_next = (enable_reg & ~(32'hFF << byte_sh))
                                      | ({24'd0, wdata & enable_keep(ofs[1:0])} << byte_sh);
                    end
                    if (hit_pending)
                    begin
                        // Writing a one acknowledges that flag.
                        pending_next = pending_reg & ~byte_field;
                    end
                    if (hit_post)
                    begin
                        post_next = {wdata[1], post_reg[0] | wdata[0]};
                    end
                end
                OP_REQUEST:
                begin
                    pending_next = pending_reg | req_bits;
                end
                default:
                begin
                    // Undefined kind: no change, empty result.
                end
            endcase
            irq_next = master_next && ((enable_next & pending_next) != 32'd0);
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg    <= 1'b0;
            enable_reg    <= 32'd0;
            pending_reg   <= 32'd0;
            post_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            master_reg    <= master_next;
            enable_reg    <= enable_next;
            pending_reg   <= pending_next;
            post_reg      <= post_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
        irq_reg   <= irq_next;
        miss_reg  <= miss_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, miss_reg, irq_reg, rdata_reg};

    // A missed access never returns data.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && miss_reg) |-> (rdata_reg == 8'd0))
        else $error("miss result carries nonzero read data");

    // A pending result shows the interrupt level of the current state.
    a_irq_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (irq_reg == (master_reg && ((enable_reg & pending_reg) != 32'd0))))
        else $error("irq_line disagrees with register state");

    // Unimplemented enable bits never get set.
    a_enable_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (enable_reg & ~ENABLE_IMPL) == 32'd0)
        else $error("unimplemented enable mask bit set");

endmodule

// File: verif/interrupt_master_enable_flag_regs_tb.sv
// ----------------------------------------------------------------------------
// interrupt_master_enable_flag_regs_tb
// Self-checking bench for the interrupt enable and flag register block. It
// keeps a shadow copy of the master enable, enable mask, pending flags and
// power-on flag, predicts the reply to every accepted item and checks each
// reply field by field. A short directed sweep covers the register map
// edges, then random accesses run under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module interrupt_master_enable_flag_regs_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import imefr_pkg::*;

    // Kind code that the block leaves unassigned; such an item changes nothing.
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int unsigned ITEMS_PER_PHASE = 280;
    localparam int unsigned DRAIN_LIMIT     = 10000;

    // Shadow registers of the block and the replies still owed by it.
    class imefr_shadow;
        typedef struct packed {
            logic [7:0] read_data;
            logic       irq_line;
            logic       miss;
        } reply_t;

        logic        master_en;
        logic [31:0] en_mask;
        logic [31:0] pend;
        logic [1:0]  post;
        reply_t      replies[$];
        int unsigned mismatches;

        function new();
            master_en  = 1'b0;
            en_mask    = '0;
            pend       = '0;
            post       = '0;
            mismatches = 0;
        endfunction

        // Apply one accepted item to the shadow and queue its reply.
        function void apply_access(input logic [1:0] op, input logic [11:0] ofs,
                                   input logic [7:0] wd, input logic [31:0] req);
            reply_t      r;
            logic        is_rd;
            int unsigned sh;
            r     = '0;
            is_rd = (op == OP_READ);
            if (op == OP_READ || op == OP_WRITE) begin
                if (ofs == OFS_MASTER) begin
                    if (is_rd)
                        r.read_data = {7'd0, master_en};
                    else
                        master_en = wd[0];
                end else if (ofs > OFS_MASTER && ofs <= OFS_MASTER + 3) begin
                    // Reserved bytes next to the master enable: silent.
                end else if (ofs >= OFS_ENABLE && ofs <= OFS_ENABLE + 3) begin
                    sh = 8 * (ofs - OFS_ENABLE);
                    if (is_rd)
                        r.read_data = en_mask[sh +: 8];
                    else
                        en_mask[sh +: 8] = wd & ENABLE_IMPL[sh +: 8];
                end else if (ofs >= OFS_PENDING && ofs <= OFS_PENDING + 3) begin
                    sh = 8 * (ofs - OFS_PENDING);
                    if (is_rd)
                        r.read_data = pend[sh +: 8];
                    else
                        pend[sh +: 8] = pend[sh +: 8] & ~wd;
                end else if (ofs == OFS_POST) begin
                    if (is_rd)
                        r.read_data = {6'd0, post};
                    else
                        post = {wd[1], post[0] | wd[0]};
                end else begin
                    r.miss = 1'b1;
                end
            end else if (op == OP_REQUEST) begin
                pend = pend | req;
            end
            r.irq_line = master_en & (|(en_mask & pend));
            replies.push_back(r);
        endfunction

        // Compare one reply word with the oldest prediction.
        function void check_reply(input logic [OUT_DATA_W-1:0] word);
            reply_t want;
            if (replies.size() == 0) begin
                $error("reply %h arrived with none outstanding", word);
                mismatches++;
                return;
            end
            want = replies.pop_front();
            if (word[7:0] !== want.read_data) begin
                $error("read_data: expected %h, got %h", want.read_data, word[7:0]);
                mismatches++;
            end
            if (word[8] !== want.irq_line) begin
                $error("irq_line: expected %b, got %b", want.irq_line, word[8]);
                mismatches++;
            end
            if (word[9] !== want.miss) begin
                $error("miss: expected %b, got %b", want.miss, word[9]);
                mismatches++;
            end
            if (word[OUT_DATA_W-1:10] !== '0) begin
                $error("padding: expected 0, got %h", word[OUT_DATA_W-1:10]);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [11:0] io_offset, [19:12] write_data, [51:20] request_bits, rest zero
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // [1:0] operation
    logic [1:0]            s_tuser = OP_READ;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [7:0] read_data, [8] irq_line, [9] miss, rest zero
    logic [OUT_DATA_W-1:0] m_tdata;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    imefr_shadow shadow = new();

    interrupt_master_enable_flag_regs i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver side: take replies, stall at random, check each one taken.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            shadow.check_reply(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one item, idling first at random, and wait until it is taken.
    task automatic send_item(input logic [1:0] op, input logic [11:0] ofs,
                             input logic [7:0] wd, input logic [31:0] req);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, req, wd, ofs};
        do
            @(posedge clk);
        while (!s_tready);
        shadow.apply_access(op, ofs, wd, req);
    endtask

    // Hold the sender off until every outstanding reply has been checked.
    task automatic wait_for_replies();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (shadow.replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (shadow.replies.size() != 0) begin
            $error("%0d replies never arrived", shadow.replies.size());
            shadow.mismatches++;
        end
    endtask

    // Hard stop in case the handshake hangs.
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [1:0]  op;
        logic [11:0] ofs;
        logic [7:0]  wd;
        logic [31:0] req;
        int unsigned pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values, map edges, masks, sticky bit, odd kinds.
        send_item(OP_READ,    OFS_MASTER,          8'h00, 32'h0);
        send_item(OP_READ,    OFS_MASTER + 12'd3,  8'h00, 32'h0);
        send_item(OP_READ,    OFS_ENABLE,          8'h00, 32'h0);
        send_item(OP_READ,    OFS_PENDING + 12'd3, 8'h00, 32'h0);
        send_item(OP_READ,    OFS_POST,            8'h00, 32'h0);
        send_item(OP_READ,    12'h000,             8'h00, 32'h0);
        send_item(OP_READ,    12'hFFF,             8'hFF, 32'hFFFF_FFFF);
        send_item(OP_READ,    OFS_MASTER + 12'd4,  8'h00, 32'h0);
        send_item(OP_REQUEST, 12'hFFF,             8'hFF, 32'hFFFF_FFFF);
        send_item(OP_WRITE,   OFS_MASTER,          8'hFF, 32'h0);
        send_item(OP_WRITE,   OFS_ENABLE,          8'hFF, 32'h0);
        send_item(OP_WRITE,   OFS_ENABLE + 12'd1,  8'hFF, 32'h0);
        send_item(OP_WRITE,   OFS_ENABLE + 12'd2,  8'hFF, 32'h0);
        send_item(OP_WRITE,   OFS_ENABLE + 12'd3,  8'hFF, 32'h0);
        send_item(OP_READ,    OFS_ENABLE + 12'd3,  8'h00, 32'h0);
        send_item(OP_WRITE,   OFS_PENDING,         8'hFF, 32'h0);
        send_item(OP_WRITE,   OFS_PENDING + 12'd3, 8'hA5, 32'h0);
        send_item(OP_READ,    OFS_PENDING + 12'd3, 8'h00, 32'h0);
        send_item(OP_WRITE,   OFS_POST,            8'hFF, 32'h0);
        send_item(OP_WRITE,   OFS_POST,            8'h00, 32'h0);
        send_item(OP_READ,    OFS_POST,            8'h00, 32'h0);
        send_item(OP_WRITE,   12'hFFF,             8'hFF, 32'h0);
        send_item(OP_WRITE,   OFS_MASTER + 12'd1,  8'hFF, 32'h0);
        send_item(OP_NONE,    OFS_MASTER,          8'hFF, 32'hFFFF_FFFF);
        send_item(OP_WRITE,   OFS_MASTER,          8'hFE, 32'h0);
        wait_for_replies();

        // Random phases: no idling, sender idle, receiver stalling, both light.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    op = OP_READ;
                else if (pick < 70)
                    op = OP_WRITE;
                else if (pick < 93)
                    op = OP_REQUEST;
                else
                    op = OP_NONE;
                // Mostly decoded offsets, some anywhere in the 12-bit space.
                pick = $urandom_range(0, 15);
                if (pick < 4)
                    ofs = OFS_MASTER + 12'(pick);
                else if (pick < 12)
                    ofs = OFS_ENABLE + 12'(pick - 4);
                else if (pick == 12)
                    ofs = OFS_POST;
                else
                    ofs = 12'($urandom_range(0, 4095));
                wd = 8'($urandom_range(0, 255));
                // Single request bits keep the irq level moving both ways.
                if ($urandom_range(0, 9) < 3)
                    req = $urandom;
                else
                    req = 32'd1 << $urandom_range(0, 31);
                send_item(op, ofs, wd, req);
            end
            wait_for_replies();
        end

        repeat (4) @(posedge clk);
        if (shadow.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
